// ===== design/lrus_pkg.sv =====
// Shared types and constants for the LRU key set unit.
package lrus_pkg;

  // Request kinds carried on in_kind.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  // Capacity register value after reset.
  localparam logic [4:0] CFG_CAP_RESET = 5'd16;

  // Commands broadcast to every cell when a request commits.
  typedef enum logic [2:0] {
    UPD_NONE    = 3'd0,
    UPD_TOUCH   = 3'd1,
    UPD_INSERT  = 3'd2,
    UPD_REPLACE = 3'd3,
    UPD_REMOVE  = 3'd4
  } upd_op_t;

  // Control part of the search record that travels down the cell chain.
  typedef struct packed {
    logic active;
    logic hit;
    logic free_found;
    logic ev_found;
  } scan_ctl_t;

endpackage

// ===== design/lrus_cell.sv =====
// One storage cell of the LRU key set: key, valid mark, recency rank and a search stage.
module lrus_cell #(
  parameter int KEY_BITS  = 32,
  parameter int RANK_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrus_pkg::scan_ctl_t   scan_ctl_i,
  input  logic [KEY_BITS-1:0]   scan_key_i,
  input  logic [RANK_BITS-1:0]  scan_rank_i,
  input  logic [KEY_BITS-1:0]   scan_evkey_i,
  output lrus_pkg::scan_ctl_t   scan_ctl_o,
  output logic [KEY_BITS-1:0]   scan_key_o,
  output logic [RANK_BITS-1:0]  scan_rank_o,
  output logic [KEY_BITS-1:0]   scan_evkey_o,
  input  lrus_pkg::upd_op_t     upd_op_i,
  input  logic [RANK_BITS-1:0]  upd_rank_i,
  input  logic [RANK_BITS-1:0]  ev_rank_i,
  input  logic [KEY_BITS-1:0]   upd_key_i
);

  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic                 valid_r, valid_nxt;
  logic [RANK_BITS-1:0] rank_r, rank_nxt;
  logic                 hit_f_r;
  logic                 claim_f_r;
  lrus_pkg::scan_ctl_t  scan_ctl_r, scan_ctl_nxt;
  logic [KEY_BITS-1:0]  scan_key_r;
  logic [RANK_BITS-1:0] scan_rank_r;
  logic [KEY_BITS-1:0]  scan_evkey_r;
  logic                 own_hit;
  logic                 own_ev;

  assign own_hit = valid_r && (key_r == scan_key_i);
  assign own_ev  = valid_r && (rank_r == ev_rank_i);

  always_comb begin
    scan_ctl_nxt.active     = scan_ctl_i.active;
    scan_ctl_nxt.hit        = scan_ctl_i.hit | own_hit;
    scan_ctl_nxt.free_found = scan_ctl_i.free_found | ~valid_r;
    scan_ctl_nxt.ev_found   = scan_ctl_i.ev_found | own_ev;
  end

  // Apply the committed command; ranks of the other valid cells shift by one.
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    case (upd_op_i)
      lrus_pkg::UPD_TOUCH: begin
        if (hit_f_r) begin
          rank_nxt = '0;
        end else if (valid_r && (rank_r < upd_rank_i)) begin
          rank_nxt = rank_r + RANK_BITS'(1);
        end
      end
      lrus_pkg::UPD_INSERT: begin
        if (claim_f_r) begin
          key_nxt   = upd_key_i;
          valid_nxt = 1'b1;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_BITS'(1);
        end
      end
      lrus_pkg::UPD_REPLACE: begin
        if (own_ev) begin
          key_nxt  = upd_key_i;
          rank_nxt = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_BITS'(1);
        end
      end
      lrus_pkg::UPD_REMOVE: begin
        if (hit_f_r) begin
          valid_nxt = 1'b0;
        end else if (valid_r && (rank_r > upd_rank_i)) begin
          rank_nxt = rank_r - RANK_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      scan_ctl_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      scan_ctl_r <= scan_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rank_r <= rank_nxt;
    if (scan_ctl_i.active) begin
      hit_f_r      <= own_hit;
      claim_f_r    <= ~valid_r & ~scan_ctl_i.free_found;
      scan_key_r   <= scan_key_i;
      scan_rank_r  <= own_hit ? rank_r : scan_rank_i;
      scan_evkey_r <= own_ev ? key_r : scan_evkey_i;
    end
  end

  assign scan_ctl_o   = scan_ctl_r;
  assign scan_key_o   = scan_key_r;
  assign scan_rank_o  = scan_rank_r;
  assign scan_evkey_o = scan_evkey_r;

endmodule

// ===== design/lru_set_unit.sv =====
// Top level of the LRU key set: request control, capacity register and the cell chain.
//
// The unit holds up to CAPACITY keys in a row of cells, each with a valid mark and a
// recency rank (0 is most recent). A request adds, removes or looks up one key and
// yields exactly one result reporting presence, a remove of a missing key, an eviction
// with the evicted key, and the occupancy afterwards. A request is searched by a record
// that walks down the cell chain one cell per clock, gathering the hit, its rank, the
// lowest free cell and the least recent key; the controller then decides and broadcasts
// one update command to all cells in a single cycle. The result is registered when the
// request commits, and a commit waits while an earlier result is held and not taken;
// no new request is accepted until the current one has committed. One request is in
// flight at a time, but a finished result waits in the output register while the next
// request is accepted and searched. The capacity register may be written at any time
// the unit is idle; a value of 0 acts as 1 and a value above CAPACITY acts as CAPACITY.
// All valid marks clear at reset, so no clearing pass is needed.
module lru_set_unit #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_was_present,
  output logic        out_not_found_error,
  output logic        out_evicted,
  output logic [31:0] out_evicted_key,
  output logic [4:0]  out_occupancy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_capacity_in_use
);

  localparam int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int KEXT_BITS = (KEY_BITS > 32) ? KEY_BITS : 32;
  localparam int CMP_BITS  = (CNT_BITS > 5) ? CNT_BITS : 5;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            req_kind_r;
  logic [KEY_BITS-1:0]   req_key_r;
  lrus_pkg::scan_ctl_t   inj_r;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [4:0]            cfg_r;
  logic                  res_hit_r;
  logic                  res_free_r;
  logic [RANK_BITS-1:0]  res_rank_r;
  logic [KEY_BITS-1:0]   res_evkey_r;

  logic                  out_valid_r;
  logic                  out_was_present_r;
  logic                  out_not_found_error_r;
  logic                  out_evicted_r;
  logic [31:0]           out_evicted_key_r;
  logic [4:0]            out_occupancy_r;

  logic                  in_accept;
  logic                  commit;
  logic [KEXT_BITS-1:0]  in_key_ext;
  logic [KEXT_BITS-1:0]  evkey_ext;
  logic [CMP_BITS-1:0]   occ_ext;
  logic [CNT_BITS-1:0]   eff_cap;
  logic [CNT_BITS-1:0]   cnt_m1;
  logic                  evict_now;

  lrus_pkg::upd_op_t     dec_op;
  lrus_pkg::upd_op_t     upd_op;
  logic                  dec_present;
  logic                  dec_err;
  logic                  dec_ev;

  // Chain wiring: element 0 is fed by the controller, element CAPACITY leaves the last cell.
  lrus_pkg::scan_ctl_t   ch_ctl   [CAPACITY+1];
  logic [KEY_BITS-1:0]   ch_key   [CAPACITY+1];
  logic [RANK_BITS-1:0]  ch_rank  [CAPACITY+1];
  logic [KEY_BITS-1:0]   ch_evkey [CAPACITY+1];
  logic [CAPACITY-1:0]   ch_active;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign commit    = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);

  // Only the low KEY_BITS bits of a key take part.
  assign in_key_ext = KEXT_BITS'(in_key);

  // Capacity in effect, clamped to the range 1 to CAPACITY.
  always_comb begin
    if (CMP_BITS'(cfg_r) > CMP_BITS'(CAPACITY)) begin
      eff_cap = CNT_BITS'(CAPACITY);
    end else if (cfg_r == 5'd0) begin
      eff_cap = CNT_BITS'(1);
    end else begin
      eff_cap = CNT_BITS'(cfg_r);
    end
  end

  // The least recent valid cell holds rank count - 1.
  assign cnt_m1    = cnt_r - CNT_BITS'(1);
  assign evict_now = (cnt_r >= eff_cap);

  // Decide what the request does once the search record has returned.
  always_comb begin
    dec_op      = lrus_pkg::UPD_NONE;
    dec_present = 1'b0;
    dec_err     = 1'b0;
    dec_ev      = 1'b0;
    cnt_nxt     = cnt_r;
    unique case (req_kind_r)
      lrus_pkg::KIND_ADD: begin
        if (res_hit_r) begin
          dec_present = 1'b1;
          dec_op      = lrus_pkg::UPD_TOUCH;
        end else if (evict_now) begin
          // The new key takes over the least recent cell, so occupancy is unchanged.
          dec_ev = 1'b1;
          dec_op = lrus_pkg::UPD_REPLACE;
        end else begin
          dec_op  = lrus_pkg::UPD_INSERT;
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
      end
      lrus_pkg::KIND_REMOVE: begin
        if (res_hit_r) begin
          dec_present = 1'b1;
          dec_op      = lrus_pkg::UPD_REMOVE;
          cnt_nxt     = cnt_r - CNT_BITS'(1);
        end else begin
          dec_err = 1'b1;
        end
      end
      lrus_pkg::KIND_LOOKUP: begin
        if (res_hit_r) begin
          dec_present = 1'b1;
          dec_op      = lrus_pkg::UPD_TOUCH;
        end
      end
      default: begin
      end
    endcase
  end

  assign upd_op    = commit ? dec_op : lrus_pkg::UPD_NONE;
  assign evkey_ext = KEXT_BITS'(res_evkey_r);
  assign occ_ext   = CMP_BITS'(cnt_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ch_ctl[CAPACITY].active) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inj_r       <= '0;
      cnt_r       <= '0;
      cfg_r       <= lrus_pkg::CFG_CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inj_r   <= '{active: in_accept, default: 1'b0};
      if (cfg_valid) begin
        cfg_r <= cfg_capacity_in_use;
      end
      if (commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_kind_r <= in_kind;
      req_key_r  <= in_key_ext[KEY_BITS-1:0];
    end
    if ((state_r == ST_SCAN) && ch_ctl[CAPACITY].active) begin
      res_hit_r   <= ch_ctl[CAPACITY].hit;
      res_free_r  <= ch_ctl[CAPACITY].free_found;
      res_rank_r  <= ch_rank[CAPACITY];
      res_evkey_r <= ch_evkey[CAPACITY];
    end
    if (commit) begin
      out_was_present_r     <= dec_present;
      out_not_found_error_r <= dec_err;
      out_evicted_r         <= dec_ev;
      out_evicted_key_r     <= dec_ev ? evkey_ext[31:0] : 32'd0;
      out_occupancy_r       <= occ_ext[4:0];
    end
  end

  assign ch_ctl[0]   = inj_r;
  assign ch_key[0]   = req_key_r;
  assign ch_rank[0]  = '0;
  assign ch_evkey[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lrus_cell #(
      .KEY_BITS  (KEY_BITS),
      .RANK_BITS (RANK_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .scan_ctl_i   (ch_ctl[i]),
      .scan_key_i   (ch_key[i]),
      .scan_rank_i  (ch_rank[i]),
      .scan_evkey_i (ch_evkey[i]),
      .scan_ctl_o   (ch_ctl[i+1]),
      .scan_key_o   (ch_key[i+1]),
      .scan_rank_o  (ch_rank[i+1]),
      .scan_evkey_o (ch_evkey[i+1]),
      .upd_op_i     (upd_op),
      .upd_rank_i   (res_rank_r),
      .ev_rank_i    (cnt_m1[RANK_BITS-1:0]),
      .upd_key_i    (req_key_r)
    );
    assign ch_active[i] = ch_ctl[i+1].active;
  end

  assign out_valid           = out_valid_r;
  assign out_was_present     = out_was_present_r;
  assign out_not_found_error = out_not_found_error_r;
  assign out_evicted         = out_evicted_r;
  assign out_evicted_key     = out_evicted_key_r;
  assign out_occupancy       = out_occupancy_r;

  // Only one search record may be in the chain at any time.
  a_one_record: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({inj_r.active, ch_active}))
    else $error("more than one search record in the cell chain");

  // A nonempty set always has a cell holding the least recent rank.
  a_lru_found: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_ctl[CAPACITY].active && (cnt_r != '0)) |-> ch_ctl[CAPACITY].ev_found)
    else $error("no least recent cell found in a nonempty set");

  // An insert without eviction must have found a free cell.
  a_free_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (dec_op == lrus_pkg::UPD_INSERT)) |-> res_free_r)
    else $error("insert committed with no free cell");

  // Occupancy never exceeds the number of cells.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_BITS'(cnt_r) <= CMP_BITS'(CAPACITY))
    else $error("occupancy above capacity");

  // A result is produced only from a committed request.
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_COMMIT))
    else $error("result raised without a commit");

endmodule
